// ===== src/halving_credit_thread_scheduler_top_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HALVING_CREDIT_THREAD_SCHEDULER_TOP_MACROS_SVH
`define HALVING_CREDIT_THREAD_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define HCTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HCTS_ASSERT_NOW(lbl, ante, cons, msg)
`define HCTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/hcts_pkg.sv =====
`timescale 1ns / 1ps

package hcts_pkg;

    localparam int THREADS_DEFAULT   = 4;
    localparam int PRIO_BITS_DEFAULT = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ACT_W      = 3;
    localparam int PRIO_REGS  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO0  = 3'd1;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 3'd1;
    localparam int               PRIO_RESET   = 5;

    // Item payload
    localparam int TID_IN_W = 2;
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    // Per-transaction control seen by every cell
    typedef struct packed {
        logic sel_go;
        logic step_go;
        logic reload;
    } cell_ctl_t;

endpackage

// ===== src/hcts_if.sv =====
`timescale 1ns / 1ps

interface hcts_item_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [hcts_pkg::TID_IN_W-1:0] thread_id;

    modport source (output valid, output op, output thread_id, input ready);
    modport sink   (input valid, input op, input thread_id, output ready);
endinterface

interface hcts_result_if;
    logic                          valid;
    logic                          ready;
    logic [hcts_pkg::TID_IN_W-1:0] chosen;
    logic                          none_ready;
    logic                          slice_over;

    modport source (output valid, output chosen, output none_ready, output slice_over,
                    input ready);
    modport sink   (input valid, input chosen, input none_ready, input slice_over,
                    output ready);
endinterface

interface hcts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hcts_pkg::CFG_IDX_W-1:0]  index;
    logic [hcts_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/hcts_cell.sv =====
`timescale 1ns / 1ps

module hcts_cell #(
    parameter int CELL_ID   = 0,
    parameter int TID_W     = 2,
    parameter int PRIO_BITS = hcts_pkg::PRIO_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hcts_pkg::cell_ctl_t   ctl,
    input  logic                  active,
    input  logic                  step_hit,
    input  logic                  prio_we,
    input  logic [PRIO_BITS-1:0]  prio_wdata,
    input  logic                  found_c_in,
    input  logic [TID_W-1:0]      idx_c_in,
    input  logic                  found_p_in,
    input  logic [TID_W-1:0]      idx_p_in,
    output logic                  found_c_out,
    output logic [TID_W-1:0]      idx_c_out,
    output logic                  found_p_out,
    output logic [TID_W-1:0]      idx_p_out,
    output logic                  drained
);

    localparam logic [TID_W-1:0] MY_IDX = TID_W'(CELL_ID);

    logic [PRIO_BITS-1:0] credit_reg;
    logic [PRIO_BITS-1:0] credit_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] halved;
    logic                 has_credit;
    logic                 has_prio;

    assign halved     = credit_reg >> 1;
    assign has_credit = active && (credit_reg != '0);
    assign has_prio   = active && (prio_reg != '0);
    assign drained    = (halved == '0);

    // Lowest-numbered candidate wins: pass on what arrived if it is already found
    assign found_c_out = found_c_in || has_credit;
    assign idx_c_out   = found_c_in ? idx_c_in : (has_credit ? MY_IDX : idx_c_in);
    assign found_p_out = found_p_in || has_prio;
    assign idx_p_out   = found_p_in ? idx_p_in : (has_prio ? MY_IDX : idx_p_in);

    always_comb
    begin
        credit_next = credit_reg;
        if (ctl.sel_go && ctl.reload && active)
        begin
            credit_next = prio_reg;
        end
        else if (ctl.step_go && step_hit)
        begin
            credit_next = halved;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            prio_reg   <= PRIO_BITS'(hcts_pkg::PRIO_RESET);
        end
        else
        begin
            credit_reg <= credit_next;
            if (prio_we)
            begin
                prio_reg <= prio_wdata;
            end
        end
    end

endmodule

// ===== src/halving_credit_thread_scheduler_top.sv =====
`timescale 1ns / 1ps
// Credit-based thread scheduler with halving credit.
// Channels: item (op, thread_id) in, result (chosen, none_ready, slice_over)
// out, cfg (index, data) for the register writes. All are valid/ready.
// A select item returns the lowest active thread with credit left; when no
// active thread has any, credits are reloaded from the priorities first.
// A step item halves the stepped thread's credit and flags slice_over once
// it reaches zero.
// Latency: the result is registered and appears in the cycle after the item transaction.
// Throughput: one item per cycle unless a waiting result is held; the whole
// decision is resolved by a ripple through the row of per-thread cells, one
// cell per thread, so the path grows with THREADS.
// Reset: credits clear to zero, one active thread, every priority is 5.
// Stall: the result holds in its output register; a new item is taken in
// the same cycle the waiting result is taken, otherwise item.ready drops.
// Configuration writes are always taken and should be issued while idle.
`include "halving_credit_thread_scheduler_top_macros.svh"

module halving_credit_thread_scheduler_top #(
    parameter int THREADS   = hcts_pkg::THREADS_DEFAULT,
    parameter int PRIO_BITS = hcts_pkg::PRIO_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    hcts_item_if.sink      item,
    hcts_result_if.source  result,
    hcts_cfg_if.sink       cfg
);

    localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;

    logic [hcts_pkg::ACT_W-1:0] active_threads_reg;

    logic                      res_valid_reg;
    logic [hcts_pkg::TID_IN_W-1:0] chosen_reg;
    logic                      none_reg;
    logic                      over_reg;

    logic                      item_acc;
    logic                      cfg_acc;
    hcts_pkg::cell_ctl_t       ctl;

    logic [THREADS:0]          found_c;
    logic [THREADS:0]          found_p;
    logic [TID_W-1:0]          idx_c [THREADS+1];
    logic [TID_W-1:0]          idx_p [THREADS+1];
    logic [THREADS-1:0]        act_vec;
    logic [THREADS-1:0]        hit_vec;
    logic [THREADS-1:0]        drained_vec;
    logic [THREADS-1:0]        prio_we_vec;

    logic [hcts_pkg::TID_IN_W-1:0] chosen_next;
    logic                      none_next;
    logic                      over_next;

    assign item_acc   = item.valid && item.ready;
    assign cfg_acc    = cfg.valid && cfg.ready;
    assign item.ready = !res_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid      = res_valid_reg;
    assign result.chosen     = chosen_reg;
    assign result.none_ready = none_reg;
    assign result.slice_over = over_reg;

    assign ctl.sel_go  = item_acc && (item.op == hcts_pkg::OP_SELECT);
    assign ctl.step_go = item_acc && (item.op == hcts_pkg::OP_STEP);
    assign ctl.reload  = !found_c[THREADS];

    assign found_c[0] = 1'b0;
    assign found_p[0] = 1'b0;
    assign idx_c[0]   = '0;
    assign idx_p[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < THREADS; gi++)
        begin : g_cell
            assign act_vec[gi] = (32'(active_threads_reg) > gi);
            assign hit_vec[gi] = act_vec[gi] && (32'(item.thread_id) == gi);

            if (gi < hcts_pkg::PRIO_REGS)
            begin : g_we
                assign prio_we_vec[gi] = cfg_acc &&
                    (cfg.index == hcts_pkg::REG_PRIO0 + hcts_pkg::CFG_IDX_W'(gi));
            end
            else
            begin : g_no_we
                assign prio_we_vec[gi] = 1'b0;
            end

            hcts_cell #(
                .CELL_ID   (gi),
                .TID_W     (TID_W),
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .active      (act_vec[gi]),
                .step_hit    (hit_vec[gi]),
                .prio_we     (prio_we_vec[gi]),
                .prio_wdata  (PRIO_BITS'(cfg.data)),
                .found_c_in  (found_c[gi]),
                .idx_c_in    (idx_c[gi]),
                .found_p_in  (found_p[gi]),
                .idx_p_in    (idx_p[gi]),
                .found_c_out (found_c[gi+1]),
                .idx_c_out   (idx_c[gi+1]),
                .found_p_out (found_p[gi+1]),
                .idx_p_out   (idx_p[gi+1]),
                .drained     (drained_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        chosen_next = '0;
        none_next   = 1'b0;
        over_next   = 1'b0;
        case (item.op)
            hcts_pkg::OP_SELECT:
            begin
                if (found_c[THREADS])
                begin
                    chosen_next = hcts_pkg::TID_IN_W'(idx_c[THREADS]);
                end
                else if (found_p[THREADS])
                begin
                    chosen_next = hcts_pkg::TID_IN_W'(idx_p[THREADS]);
                end
                else
                begin
                    none_next = 1'b1;
                end
            end
            hcts_pkg::OP_STEP:
            begin
                chosen_next = item.thread_id;
                // An inactive or absent thread counts as out of slice
                over_next   = (hit_vec == '0) || ((hit_vec & drained_vec) != '0);
            end
            default:
            begin
                chosen_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threads_reg <= hcts_pkg::ACTIVE_RESET;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_acc && (cfg.index == hcts_pkg::REG_ACTIVE))
            begin
                active_threads_reg <= cfg.data[hcts_pkg::ACT_W-1:0];
            end
            if (item_acc)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            chosen_reg <= chosen_next;
            none_reg   <= none_next;
            over_reg   <= over_next;
        end
    end

    `HCTS_ASSERT_NOW(a_hit_onehot, 1'b1, $onehot0(hit_vec), "several cells hit by one step")
    `HCTS_ASSERT_NOW(a_none_zero, res_valid_reg && none_reg, chosen_reg == '0,
        "none_ready with nonzero chosen")
    `HCTS_ASSERT_NEXT(a_found_not_none, ctl.sel_go && found_p[THREADS], !none_reg,
        "runnable thread reported as none_ready")
    `HCTS_ASSERT_NEXT(a_select_no_over, ctl.sel_go, !over_reg && res_valid_reg,
        "select result flags slice_over")

endmodule

// ===== test/hcts_decision_checker.sv =====
`timescale 1ns / 1ps

module hcts_decision_checker (
    input  logic   clk,
    input  logic   rst_n,
    hcts_item_if   item,
    hcts_result_if result,
    hcts_cfg_if    cfg,
    output int     mismatches,
    output int     outstanding,
    output int     checked,
    output int     reloads
);
    import hcts_pkg::*;

    localparam int THREADS = THREADS_DEFAULT;

    typedef struct packed {
        logic [TID_IN_W-1:0] chosen;
        logic                none_ready;
        logic                slice_over;
    } decision_t;

    decision_t                expected_decisions[$];
    logic [ACT_W-1:0]         active_cnt;
    logic [CFG_DATA_W-1:0]    reload_val[THREADS];
    logic [CFG_DATA_W-1:0]    credit_left[THREADS];

    int fail_total   = 0;
    int seen_total   = 0;
    int reload_total = 0;

    assign mismatches = fail_total;
    assign checked    = seen_total;
    assign reloads    = reload_total;

    function automatic int live_threads();
        return (int'(active_cnt) > THREADS) ? THREADS : int'(active_cnt);
    endfunction

    function automatic int first_with_credit();
        int pick;
        pick = -1;
        for (int n = 0; n < live_threads(); n++)
            if (pick < 0 && credit_left[n] != '0)
                pick = n;
        return pick;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        if (idx == REG_ACTIVE)
            active_cnt = val[ACT_W-1:0];
        else if (idx >= REG_PRIO0 && idx < REG_PRIO0 + PRIO_REGS)
            reload_val[idx - REG_PRIO0] = val;
    endfunction

    function automatic decision_t predict_decision(logic op, logic [TID_IN_W-1:0] tid);
        decision_t d;
        int        pick;
        d = '0;
        if (op == OP_SELECT) begin
            pick = first_with_credit();
            if (pick < 0) begin
                // refill every live thread from its priority, then rescan
                for (int n = 0; n < live_threads(); n++)
                    credit_left[n] = reload_val[n];
                reload_total++;
                pick = first_with_credit();
            end
            if (pick < 0)
                d.none_ready = 1'b1;
            else
                d.chosen = TID_IN_W'(pick);
        end
        else begin
            d.chosen = tid;
            if (int'(tid) < live_threads()) begin
                credit_left[tid] = credit_left[tid] >> 1;
                d.slice_over     = (credit_left[tid] == '0);
            end
            else
                d.slice_over = 1'b1;
        end
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            active_cnt = ACTIVE_RESET;
            for (int n = 0; n < THREADS; n++)
            begin
                reload_val[n]  = CFG_DATA_W'(PRIO_RESET);
                credit_left[n] = '0;
            end
            expected_decisions.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_register(cfg.index, cfg.data);
            if (item.valid && item.ready)
                expected_decisions.push_back(predict_decision(item.op, item.thread_id));
            if (result.valid && result.ready)
            begin
                seen_total++;
                if (expected_decisions.size() == 0)
                begin
                    $error("unexpected result transaction: chosen %0d none_ready %0b slice_over %0b",
                           result.chosen, result.none_ready, result.slice_over);
                    fail_total++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (result.chosen !== want.chosen)
                    begin
                        $error("chosen: expected %0d, got %0d", want.chosen, result.chosen);
                        fail_total++;
                    end
                    if (result.none_ready !== want.none_ready)
                    begin
                        $error("none_ready: expected %0b, got %0b",
                               want.none_ready, result.none_ready);
                        fail_total++;
                    end
                    if (result.slice_over !== want.slice_over)
                    begin
                        $error("slice_over: expected %0b, got %0b",
                               want.slice_over, result.slice_over);
                        fail_total++;
                    end
                end
            end
        end
        outstanding = expected_decisions.size();
    end

endmodule

// ===== test/tb_halving_credit_thread_scheduler_top.sv =====
`timescale 1ns / 1ps

module tb_halving_credit_thread_scheduler_top;
    import hcts_pkg::*;

    localparam int                   CYCLE_LIMIT   = 200000;
    localparam int                   RANDOM_PHASES = 8;
    localparam int                   PHASE_ITEMS   = 118;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

    logic clk;
    logic rst_n;

    int               send_idle_pct;
    int               recv_stall_pct;
    int               items_sent;
    int               settings_used;
    logic [ACT_W-1:0] cur_active;

    int mismatches;
    int outstanding;
    int checked;
    int reloads;

    hcts_item_if   item_ch ();
    hcts_result_if result_ch ();
    hcts_cfg_if    cfg_ch ();

    halving_credit_thread_scheduler_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    hcts_decision_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .reloads     (reloads)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == REG_ACTIVE)
            cur_active = val[ACT_W-1:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_item(input logic op, input logic [TID_IN_W-1:0] tid);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.op        <= op;
        item_ch.thread_id <= tid;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    // drop valid and hold until every decision has come back
    task automatic hold_off();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_prio();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return 8'd1;
            3:       return 8'($urandom_range(7, 2));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_active();
        logic [ACT_W-1:0] cnt;
        case ($urandom_range(9))
            0:       cnt = '0;
            1:       cnt = 3'($urandom_range(7, 5));
            default: cnt = 3'($urandom_range(4, 1));
        endcase
        // upper data bits carry noise; only the low bits count
        return {5'($urandom), cnt};
    endfunction

    task automatic program_random_setting();
        write_reg(REG_ACTIVE, pick_active());
        for (int n = 0; n < PRIO_REGS; n++)
            write_reg(REG_PRIO0 + 3'(n), pick_prio());
        if ($urandom_range(3) == 0)
            write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 8'($urandom));
        settings_used++;
    endtask

    task automatic random_item();
        int                  live;
        logic                op;
        logic [TID_IN_W-1:0] tid;
        live = (cur_active > THREADS_DEFAULT) ? THREADS_DEFAULT : int'(cur_active);
        op   = ($urandom_range(99) < 70) ? OP_STEP : OP_SELECT;
        // mostly steps of live threads, some of idle or absent ones
        if (live > 0 && $urandom_range(9) < 8)
            tid = TID_IN_W'($urandom_range(live - 1));
        else
            tid = TID_IN_W'($urandom_range(3));
        push_item(op, tid);
    endtask

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.op        = OP_SELECT;
        item_ch.thread_id = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_ACTIVE;
        cfg_ch.data       = '0;
        result_ch.ready   = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        items_sent        = 0;
        settings_used     = 1;
        cur_active        = ACTIVE_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: one live thread, priority 5
        push_item(OP_SELECT, 2'd0);
        repeat (4) push_item(OP_STEP, 2'd0);
        push_item(OP_STEP, 2'd1);
        push_item(OP_STEP, 2'd2);
        push_item(OP_STEP, 2'd3);
        hold_off();

        // four live threads, priority extremes, writes to unused indexes
        write_reg(REG_ACTIVE, 8'd4);
        write_reg(REG_PRIO0, 8'd0);
        write_reg(REG_PRIO0 + 3'd1, 8'd255);
        write_reg(REG_PRIO0 + 3'd2, 8'd1);
        write_reg(REG_PRIO0 + 3'd3, 8'd128);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'hFF);
        settings_used++;
        push_item(OP_SELECT, 2'd3);
        push_item(OP_STEP, 2'd2);
        push_item(OP_SELECT, 2'd0);
        push_item(OP_STEP, 2'd1);
        push_item(OP_STEP, 2'd3);
        push_item(OP_STEP, 2'd0);
        hold_off();

        // no live thread at all
        write_reg(REG_ACTIVE, 8'd0);
        write_reg(REG_SPARE_LO + 3'd1, 8'h00);
        settings_used++;
        push_item(OP_SELECT, 2'd0);
        push_item(OP_STEP, 2'd0);
        hold_off();

        // one live thread with zero priority: nothing can run
        write_reg(REG_ACTIVE, 8'd1);
        write_reg(REG_PRIO0 + 3'd1, 8'd0);
        write_reg(REG_PRIO0 + 3'd2, 8'd0);
        write_reg(REG_PRIO0 + 3'd3, 8'd0);
        settings_used++;
        push_item(OP_SELECT, 2'd0);
        push_item(OP_STEP, 2'd0);
        hold_off();

        // count above the thread total saturates
        write_reg(REG_ACTIVE, 8'd7);
        settings_used++;
        push_item(OP_SELECT, 2'd0);
        push_item(OP_STEP, 2'd3);
        push_item(OP_STEP, 2'd1);
        hold_off();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            hold_off();
            program_random_setting();
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) == 0)
                    hold_off();
                random_item();
            end
        end

        hold_off();
        repeat (4) @(negedge clk);

        $display("Ran %0d scheduler items over %0d register settings and four idle patterns;",
                 items_sent, settings_used);
        $display("%0d results checked, %0d credit reloads predicted.", checked, reloads);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
